/* sv/arm_banked_register_file_unit_defines.svh */
// assertion macros for the banked register file unit
`ifndef ARM_BANKED_REGISTER_FILE_UNIT_DEFINES_SVH
`define ARM_BANKED_REGISTER_FILE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ABRF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("abrf: same-cycle check failed");

// next-cycle implication
`define ABRF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("abrf: next-cycle check failed");

`else

`define ABRF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ABRF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/abrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package abrf_pkg;

    // command codes
    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_SETMD  = 3'd2;
    localparam logic [2:0] CMD_EXC    = 3'd3;
    localparam logic [2:0] CMD_JUMP   = 3'd4;
    localparam logic [2:0] CMD_STATUS = 3'd5;

    // processor modes
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;

    // bank numbers
    localparam logic [2:0] BANK_USR = 3'd0;
    localparam logic [2:0] BANK_FIQ = 3'd1;
    localparam logic [2:0] BANK_SVC = 3'd2;
    localparam logic [2:0] BANK_ABT = 3'd3;
    localparam logic [2:0] BANK_IRQ = 3'd4;
    localparam logic [2:0] BANK_UND = 3'd5;

    // status word bits
    localparam int BIT_T = 5;
    localparam int BIT_F = 6;
    localparam int BIT_I = 7;

    localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;

    // storage sizes: shared r0-r15, fiq r8-r14, sp/lr of four modes
    localparam int RF_DEPTH   = 31;
    localparam int SPSR_DEPTH = 5;
    localparam logic [4:0] SLOT_FIQ_BASE = 5'd16;
    localparam logic [4:0] SLOT_SPLR_BASE = 5'd23;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_PC = 4'd15;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  reg_index;
        logic [4:0]  mode_sel;
        logic        use_current_mode;
        logic [31:0] write_value;
        logic [2:0]  exception_kind;
        logic        thumb_flag;
    } t_cmd_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] cpsr_value;
        logic [31:0] spsr_value;
    } t_result_word;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic exc_pc;
        logic resp;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_exc;
    } t_sts;

    typedef struct packed {
        logic [4:0] mode;
        logic [3:0] arm_off;
        logic [3:0] thumb_off;
        logic       set_f;
    } t_vec_info;

    // standard vector table
    function automatic t_vec_info vec_info(input logic [2:0] kind);
        t_vec_info v;
        case (kind)
            3'd0:    v = '{MODE_SVC, 4'd0, 4'd0, 1'b1};
            3'd1:    v = '{MODE_UND, 4'd4, 4'd2, 1'b0};
            3'd2:    v = '{MODE_SVC, 4'd4, 4'd2, 1'b0};
            3'd3:    v = '{MODE_ABT, 4'd4, 4'd4, 1'b0};
            3'd4:    v = '{MODE_ABT, 4'd8, 4'd8, 1'b0};
            3'd5:    v = '{MODE_SVC, 4'd0, 4'd0, 1'b0};
            3'd6:    v = '{MODE_IRQ, 4'd4, 4'd4, 1'b0};
            default: v = '{MODE_FIQ, 4'd4, 4'd4, 1'b1};
        endcase
        return v;
    endfunction

    // invalid modes fall back to the user bank
    function automatic logic [2:0] bank_of(input logic [4:0] mode);
        logic [2:0] b;
        case (mode)
            MODE_FIQ: b = BANK_FIQ;
            MODE_SVC: b = BANK_SVC;
            MODE_ABT: b = BANK_ABT;
            MODE_IRQ: b = BANK_IRQ;
            MODE_UND: b = BANK_UND;
            default:  b = BANK_USR;
        endcase
        return b;
    endfunction

    // flat register slot for a register number seen from a mode
    function automatic logic [4:0] slot_of(input logic [3:0] r, input logic [4:0] mode);
        logic [2:0] b;
        logic [2:0] bs;
        logic [4:0] s;
        b  = bank_of(mode);
        bs = b - BANK_SVC;
        if (b == BANK_FIQ && r >= 4'd8 && r <= 4'd14) begin
            s = SLOT_FIQ_BASE + {1'b0, r} - 5'd8;
        end else if (b >= BANK_SVC && (r == 4'd13 || r == REG_LR)) begin
            s = SLOT_SPLR_BASE + {2'b00, bs[1:0], 1'b0} + {4'b0000, r == REG_LR};
        end else begin
            s = {1'b0, r};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* sv/abrf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module abrf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    output logic                o_result_valid,
    input  wire abrf_pkg::t_sts i_sts,
    output abrf_pkg::t_ctl      o_ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_EXC_PC = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_strobe, n_strobe;

    // next state
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.is_exc ? S_EXC_PC : S_RESP;
            end
            S_EXC_PC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // commands to the datapath
    always_comb begin
        o_ctl.load   = start && (r_state == S_IDLE);
        o_ctl.exec   = (r_state == S_EXEC);
        o_ctl.exc_pc = (r_state == S_EXC_PC);
        o_ctl.resp   = (r_state == S_RESP);
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_strobe;

endmodule

`default_nettype wire

/* sv/abrf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module abrf_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire abrf_pkg::t_ctl         i_ctl,
    output abrf_pkg::t_sts              o_sts,
    input  wire abrf_pkg::t_cmd_word    i_cmd,
    input  wire logic                   i_cfg_we,
    input  wire logic [31:0]            i_cfg_data,
    output abrf_pkg::t_result_word      o_result
);

    abrf_pkg::t_cmd_word    r_cmd;
    abrf_pkg::t_result_word r_out;
    logic [31:0] r_rf [abrf_pkg::RF_DEPTH];
    logic [31:0] r_spsr [abrf_pkg::SPSR_DEPTH];
    logic [31:0] r_cpsr;
    logic [31:0] r_vbase;
    logic [31:0] r_rdata;

    logic [4:0]  acc_mode;
    logic [4:0]  acc_slot;
    logic [2:0]  acc_bank;
    logic [2:0]  sm_bank;
    abrf_pkg::t_vec_info vinfo;
    logic [2:0]  vbank;
    logic [4:0]  lr_slot;
    logic [31:0] pc_back;
    logic [31:0] lr_value;
    logic [31:0] vec_addr;
    logic [31:0] jump_pc;
    logic [31:0] exc_cpsr;

    // access decode, current or named mode
    always_comb begin
        acc_mode = r_cmd.use_current_mode ? r_cpsr[4:0] : r_cmd.mode_sel;
        acc_slot = abrf_pkg::slot_of(r_cmd.reg_index, acc_mode);
        acc_bank = abrf_pkg::bank_of(acc_mode);
        sm_bank  = abrf_pkg::bank_of(r_cmd.mode_sel);
    end

    // exception entry values
    always_comb begin
        vinfo    = abrf_pkg::vec_info(r_cmd.exception_kind);
        vbank    = abrf_pkg::bank_of(vinfo.mode);
        lr_slot  = abrf_pkg::slot_of(abrf_pkg::REG_LR, vinfo.mode);
        pc_back  = r_rf[{1'b0, abrf_pkg::REG_PC}]
                   - (r_cpsr[abrf_pkg::BIT_T] ? 32'd4 : 32'd8);
        lr_value = pc_back + {28'd0, r_cpsr[abrf_pkg::BIT_T] ? vinfo.thumb_off
                                                            : vinfo.arm_off};
        vec_addr = r_vbase + {27'd0, r_cmd.exception_kind, 2'b00} + 32'd8;
        exc_cpsr = {r_cpsr[31:8], 1'b1, r_cpsr[abrf_pkg::BIT_F] | vinfo.set_f, 1'b0,
                    vinfo.mode};
        jump_pc  = r_cmd.write_value + (r_cmd.thumb_flag ? 32'd4 : 32'd8);
    end

    assign o_sts.is_exc = (r_cmd.command == abrf_pkg::CMD_EXC);

    // command word and read data
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_rdata <= '0;
        end else if (i_ctl.exec && r_cmd.command == abrf_pkg::CMD_READ) begin
            r_rdata <= r_rf[acc_slot];
        end
    end

    // vector base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbase <= '0;
        end else if (i_cfg_we) begin
            r_vbase <= i_cfg_data;
        end
    end

    // register file, one write per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < abrf_pkg::RF_DEPTH; i++) r_rf[i] <= '0;
        end else if (i_ctl.exec) begin
            case (r_cmd.command)
                abrf_pkg::CMD_WRITE: r_rf[acc_slot] <= r_cmd.write_value;
                abrf_pkg::CMD_EXC:   r_rf[lr_slot] <= lr_value;
                abrf_pkg::CMD_JUMP:  r_rf[{1'b0, abrf_pkg::REG_PC}] <= jump_pc;
                default: begin
                end
            endcase
        end else if (i_ctl.exc_pc) begin
            r_rf[{1'b0, abrf_pkg::REG_PC}] <= vec_addr;
        end
    end

    // status word and saved status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpsr <= abrf_pkg::CPSR_RESET;
            for (int i = 0; i < abrf_pkg::SPSR_DEPTH; i++) r_spsr[i] <= '0;
        end else if (i_ctl.exec) begin
            case (r_cmd.command)
                abrf_pkg::CMD_SETMD: begin
                    if (sm_bank != abrf_pkg::BANK_USR) r_spsr[sm_bank - 3'd1] <= r_cpsr;
                    r_cpsr[4:0] <= r_cmd.mode_sel;
                end
                abrf_pkg::CMD_EXC: begin
                    r_spsr[vbank - 3'd1] <= r_cpsr;
                    r_cpsr <= exc_cpsr;
                end
                abrf_pkg::CMD_JUMP: begin
                    r_cpsr[abrf_pkg::BIT_T] <= r_cmd.thumb_flag;
                end
                default: begin
                end
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_ctl.resp) begin
            r_out.read_data  <= r_rdata;
            r_out.cpsr_value <= r_cpsr;
            r_out.spsr_value <= (acc_bank == abrf_pkg::BANK_USR) ? 32'd0
                                                                 : r_spsr[acc_bank - 3'd1];
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

/* sv/arm_banked_register_file_unit.sv */
// channel   | signals                      | handshake
// ----------+------------------------------+-------------------------------------
// command   | start, busy, i_cmd           | taken when start high, busy low
// result    | o_result_valid, o_result     | one-cycle strobe, cannot be held off
// config    | i_cfg_valid, o_cfg_ready,    | vector base written when valid and
//           | i_cfg_data                   | ready are both high, ready low if busy
//
// a command runs through load, execute and respond; exception entry writes LR in
// execute and PC in a step of its own, as the register file has one write port.
// the result word strobes in the cycle after the respond step; busy is already
// low then, so the next command can start in the same cycle.
// reset (synchronous, active low) clears the register file and saved status to
// zero, the status word to supervisor with I and F set, and the vector base to zero.
`timescale 1ns / 1ps
`default_nettype none

`include "arm_banked_register_file_unit_defines.svh"

module arm_banked_register_file_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire abrf_pkg::t_cmd_word    i_cmd,
    output logic                        o_result_valid,
    output abrf_pkg::t_result_word      o_result,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [31:0]            i_cfg_data
);

    abrf_pkg::t_ctl ctl;
    abrf_pkg::t_sts sts;

    // config is only written while idle
    assign o_cfg_ready = !busy;

    abrf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .i_sts          (sts),
        .o_ctl          (ctl)
    );

    abrf_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

    // result word shows while the controller is idle
    `ABRF_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_result_valid, !busy)
    // an accepted word makes the block busy
    `ABRF_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // every finished word gives a strobe when busy falls
    `ABRF_ASSERT_IMP(a_fell_strobe, i_clk, i_rst_n, $fell(busy), o_result_valid)

endmodule

`default_nettype wire
